### hdl/dmfp_pkg.sv
// shared types and codes for the dns message field parser
// no dependencies
`timescale 1ns / 1ps
package dmfp_pkg;

	localparam int NumSlots = 5;

	// parse phases
	localparam logic [4:0] PH_ID        = 5'd0;
	localparam logic [4:0] PH_FLAGS1    = 5'd1;
	localparam logic [4:0] PH_FLAGS2    = 5'd2;
	localparam logic [4:0] PH_QD        = 5'd3;
	localparam logic [4:0] PH_AN        = 5'd4;
	localparam logic [4:0] PH_NS        = 5'd5;
	localparam logic [4:0] PH_AR        = 5'd6;
	localparam logic [4:0] PH_QNAME_LEN = 5'd7;
	localparam logic [4:0] PH_QNAME_CHR = 5'd8;
	localparam logic [4:0] PH_QTYPE     = 5'd9;
	localparam logic [4:0] PH_QCLASS    = 5'd10;
	localparam logic [4:0] PH_ANAME_LEN = 5'd11;
	localparam logic [4:0] PH_ANAME_CHR = 5'd12;
	localparam logic [4:0] PH_TYPE      = 5'd13;
	localparam logic [4:0] PH_CLASS     = 5'd14;
	localparam logic [4:0] PH_TTL       = 5'd15;
	localparam logic [4:0] PH_RDLEN     = 5'd16;
	localparam logic [4:0] PH_IP        = 5'd17;
	localparam logic [4:0] PH_RNAME_LEN = 5'd18;
	localparam logic [4:0] PH_RNAME_CHR = 5'd19;
	localparam logic [4:0] PH_MXPREF    = 5'd20;
	localparam logic [4:0] PH_SKIP      = 5'd21;
	localparam logic [4:0] PH_DONE      = 5'd22;

	// field kinds
	localparam logic [4:0] K_ID       = 5'd0;
	localparam logic [4:0] K_QR       = 5'd1;
	localparam logic [4:0] K_OPCODE   = 5'd2;
	localparam logic [4:0] K_AA       = 5'd3;
	localparam logic [4:0] K_TC       = 5'd4;
	localparam logic [4:0] K_RD       = 5'd5;
	localparam logic [4:0] K_RA       = 5'd6;
	localparam logic [4:0] K_RCODE    = 5'd7;
	localparam logic [4:0] K_QDCOUNT  = 5'd8;
	localparam logic [4:0] K_QNAME    = 5'd12;
	localparam logic [4:0] K_QTYPE    = 5'd13;
	localparam logic [4:0] K_QCLASS   = 5'd14;
	localparam logic [4:0] K_ANAME    = 5'd15;
	localparam logic [4:0] K_TYPE     = 5'd16;
	localparam logic [4:0] K_CLASS    = 5'd17;
	localparam logic [4:0] K_TTL      = 5'd18;
	localparam logic [4:0] K_RDLEN    = 5'd19;
	localparam logic [4:0] K_IP       = 5'd20;
	localparam logic [4:0] K_RNAME    = 5'd21;
	localparam logic [4:0] K_MXPREF   = 5'd22;
	localparam logic [4:0] K_MXNAME   = 5'd23;
	localparam logic [4:0] K_DONE     = 5'd24;

	localparam logic [15:0] TYPE_A     = 16'd1;
	localparam logic [15:0] TYPE_NS    = 16'd2;
	localparam logic [15:0] TYPE_CNAME = 16'd5;
	localparam logic [15:0] TYPE_MX    = 16'd15;

	localparam logic [7:0] LABEL_MARK = 8'h2E;
	localparam logic [7:0] MaxNameReset = 8'd255;

	// results caused by one byte
	typedef struct packed {
		logic [2:0]                    count;
		logic [NumSlots-1:0][4:0]      kind;
		logic [NumSlots-1:0][31:0]     value;
		logic [NumSlots-1:0][15:0]     idx;
	} bundle_t;

	function automatic bundle_t push(bundle_t bd, logic [4:0] k, logic [31:0] v,
			logic [15:0] i);
		bundle_t r;
		r = bd;
		r.kind[bd.count] = k;
		r.value[bd.count] = v;
		r.idx[bd.count] = i;
		r.count = bd.count + 3'd1;
		return r;
	endfunction

endpackage

### hdl/dmfp_if.sv
// valid/ready channel interfaces for input bytes and output fields
// depends on nothing
`timescale 1ns / 1ps
interface dmfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_message;
	modport source (output valid, data_byte, start_of_message, input ready);
	modport sink (input valid, data_byte, start_of_message, output ready);
endinterface

interface dmfp_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  field_kind;
	logic [31:0] field_value;
	logic [15:0] answer_index;
	logic        last_of_run;
	modport source (output valid, field_kind, field_value, answer_index, last_of_run,
		input ready);
	modport sink (input valid, field_kind, field_value, answer_index, last_of_run,
		output ready);
endinterface

### hdl/dmfp_parser.sv
// parse state and per-byte decode into a bundle of results
// depends on dmfp_pkg
`timescale 1ns / 1ps
module dmfp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              start_of_message,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	output dmfp_pkg::bundle_t bundle
);

	logic [7:0]  max_q;
	logic [4:0]  ph_q, ph_n;
	logic [1:0]  bif_q, bif_n;
	logic [31:0] acc_q, acc_n;
	logic [7:0]  lbl_q, lbl_n;
	logic [7:0]  nce_q, nce_n;
	logic [15:0] al_q, al_n;
	logic [15:0] ca_q, ca_n;
	logic [15:0] rt_q, rt_n;
	logic [15:0] rdl_q, rdl_n;

	always_comb begin
		logic [31:0] g;
		logic        d2, d4;
		logic [4:0]  nk;
		logic [15:0] al_m;
		dmfp_pkg::bundle_t bd;
		bd = '0;
		if (start_of_message) begin
			ph_n = dmfp_pkg::PH_ID; bif_n = '0; acc_n = '0; lbl_n = '0; nce_n = '0;
			al_n = '0; ca_n = '0; rt_n = '0; rdl_n = '0;
		end else begin
			ph_n = ph_q; bif_n = bif_q; acc_n = acc_q; lbl_n = lbl_q; nce_n = nce_q;
			al_n = al_q; ca_n = ca_q; rt_n = rt_q; rdl_n = rdl_q;
		end
		// big-endian gather on the effective state
		g = (bif_n == 2'd0) ? {24'd0, data_byte} : {acc_n[23:0], data_byte};
		d2 = (bif_n != 2'd0);
		d4 = (bif_n == 2'd3);
		nk = (rt_n == dmfp_pkg::TYPE_MX) ? dmfp_pkg::K_MXNAME : dmfp_pkg::K_RNAME;
		al_m = al_n - 16'd1;
		case (ph_n)
			dmfp_pkg::PH_ID, dmfp_pkg::PH_QD, dmfp_pkg::PH_AN, dmfp_pkg::PH_NS,
			dmfp_pkg::PH_AR, dmfp_pkg::PH_QTYPE, dmfp_pkg::PH_QCLASS,
			dmfp_pkg::PH_TYPE, dmfp_pkg::PH_CLASS, dmfp_pkg::PH_RDLEN,
			dmfp_pkg::PH_MXPREF: begin
				acc_n = g;
				bif_n = d2 ? 2'd0 : 2'd1;
				if (d2) begin
					case (ph_n)
						dmfp_pkg::PH_ID: begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_ID, g, ca_n);
							ph_n = dmfp_pkg::PH_FLAGS1;
						end
						dmfp_pkg::PH_QTYPE: begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_QTYPE, g, ca_n);
							ph_n = dmfp_pkg::PH_QCLASS;
						end
						dmfp_pkg::PH_QCLASS: begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_QCLASS, g, ca_n);
							ca_n = '0;
							if (al_n == 16'd0) begin
								bd = dmfp_pkg::push(bd, dmfp_pkg::K_DONE, 32'd0, 16'd0);
								ph_n = dmfp_pkg::PH_DONE;
							end else begin
								ph_n = dmfp_pkg::PH_ANAME_LEN;
							end
						end
						dmfp_pkg::PH_TYPE: begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_TYPE, g, ca_n);
							rt_n = g[15:0];
							ph_n = dmfp_pkg::PH_CLASS;
						end
						dmfp_pkg::PH_CLASS: begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_CLASS, g, ca_n);
							ph_n = dmfp_pkg::PH_TTL;
						end
						dmfp_pkg::PH_MXPREF: begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_MXPREF, g, ca_n);
							ph_n = dmfp_pkg::PH_RNAME_LEN;
						end
						dmfp_pkg::PH_RDLEN: begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_RDLEN, g, ca_n);
							rdl_n = g[15:0];
							if (rt_n == dmfp_pkg::TYPE_A) ph_n = dmfp_pkg::PH_IP;
							else if (rt_n == dmfp_pkg::TYPE_NS || rt_n == dmfp_pkg::TYPE_CNAME)
								ph_n = dmfp_pkg::PH_RNAME_LEN;
							else if (rt_n == dmfp_pkg::TYPE_MX) ph_n = dmfp_pkg::PH_MXPREF;
							else if (g[15:0] == 16'd0) begin
								// empty unknown rdata ends the record here
								ca_n = ca_n + 16'd1;
								al_n = al_m;
								if (al_m == 16'd0) begin
									bd = dmfp_pkg::push(bd, dmfp_pkg::K_DONE, 32'd0, ca_n);
									ph_n = dmfp_pkg::PH_DONE;
								end else ph_n = dmfp_pkg::PH_ANAME_LEN;
							end else ph_n = dmfp_pkg::PH_SKIP;
						end
						default: begin
							// header counts
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_QDCOUNT + (ph_n - dmfp_pkg::PH_QD),
								g, ca_n);
							if (ph_n == dmfp_pkg::PH_AN) al_n = g[15:0];
							ph_n = ph_n + 5'd1;
						end
					endcase
				end
			end
			dmfp_pkg::PH_TTL, dmfp_pkg::PH_IP: begin
				acc_n = g;
				bif_n = d4 ? 2'd0 : bif_n + 2'd1;
				if (d4) begin
					if (ph_n == dmfp_pkg::PH_TTL) begin
						bd = dmfp_pkg::push(bd, dmfp_pkg::K_TTL, g, ca_n);
						ph_n = dmfp_pkg::PH_RDLEN;
					end else begin
						bd = dmfp_pkg::push(bd, dmfp_pkg::K_IP, g, ca_n);
						ca_n = ca_n + 16'd1;
						al_n = al_m;
						if (al_m == 16'd0) begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_DONE, 32'd0, ca_n);
							ph_n = dmfp_pkg::PH_DONE;
						end else ph_n = dmfp_pkg::PH_ANAME_LEN;
					end
				end
			end
			dmfp_pkg::PH_FLAGS1: begin
				bd = dmfp_pkg::push(bd, dmfp_pkg::K_QR, {31'd0, data_byte[7]}, ca_n);
				bd = dmfp_pkg::push(bd, dmfp_pkg::K_OPCODE, {28'd0, data_byte[6:3]}, ca_n);
				bd = dmfp_pkg::push(bd, dmfp_pkg::K_AA, {31'd0, data_byte[2]}, ca_n);
				bd = dmfp_pkg::push(bd, dmfp_pkg::K_TC, {31'd0, data_byte[1]}, ca_n);
				bd = dmfp_pkg::push(bd, dmfp_pkg::K_RD, {31'd0, data_byte[0]}, ca_n);
				ph_n = dmfp_pkg::PH_FLAGS2;
			end
			dmfp_pkg::PH_FLAGS2: begin
				bd = dmfp_pkg::push(bd, dmfp_pkg::K_RA, {31'd0, data_byte[7]}, ca_n);
				bd = dmfp_pkg::push(bd, dmfp_pkg::K_RCODE, {28'd0, data_byte[3:0]}, ca_n);
				ph_n = dmfp_pkg::PH_QD;
			end
			dmfp_pkg::PH_QNAME_LEN, dmfp_pkg::PH_ANAME_LEN, dmfp_pkg::PH_RNAME_LEN: begin
				if (data_byte == 8'd0) begin
					nce_n = '0;
					if (ph_n == dmfp_pkg::PH_QNAME_LEN) ph_n = dmfp_pkg::PH_QTYPE;
					else if (ph_n == dmfp_pkg::PH_ANAME_LEN) ph_n = dmfp_pkg::PH_TYPE;
					else begin
						ca_n = ca_n + 16'd1;
						al_n = al_m;
						if (al_m == 16'd0) begin
							bd = dmfp_pkg::push(bd, dmfp_pkg::K_DONE, 32'd0, ca_n);
							ph_n = dmfp_pkg::PH_DONE;
						end else ph_n = dmfp_pkg::PH_ANAME_LEN;
					end
				end else begin
					lbl_n = data_byte;
					ph_n = ph_n + 5'd1;
				end
			end
			dmfp_pkg::PH_QNAME_CHR, dmfp_pkg::PH_ANAME_CHR, dmfp_pkg::PH_RNAME_CHR: begin
				if (ph_n == dmfp_pkg::PH_QNAME_CHR) nk = dmfp_pkg::K_QNAME;
				else if (ph_n == dmfp_pkg::PH_ANAME_CHR) nk = dmfp_pkg::K_ANAME;
				if (nce_n < max_q) begin
					bd = dmfp_pkg::push(bd, nk, {24'd0, data_byte}, ca_n);
					nce_n = nce_n + 8'd1;
				end
				lbl_n = lbl_n - 8'd1;
				if (lbl_n == 8'd0) begin
					// label end mark
					if (nce_n < max_q) begin
						bd = dmfp_pkg::push(bd, nk, {24'd0, dmfp_pkg::LABEL_MARK}, ca_n);
						nce_n = nce_n + 8'd1;
					end
					ph_n = ph_n - 5'd1;
				end
			end
			dmfp_pkg::PH_SKIP: begin
				rdl_n = rdl_n - 16'd1;
				if (rdl_n == 16'd0) begin
					ca_n = ca_n + 16'd1;
					al_n = al_m;
					if (al_m == 16'd0) begin
						bd = dmfp_pkg::push(bd, dmfp_pkg::K_DONE, 32'd0, ca_n);
						ph_n = dmfp_pkg::PH_DONE;
					end else ph_n = dmfp_pkg::PH_ANAME_LEN;
				end
			end
			dmfp_pkg::PH_DONE: begin
			end
			default: ph_n = dmfp_pkg::PH_DONE;
		endcase
		bundle = bd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= dmfp_pkg::MaxNameReset;
			ph_q <= dmfp_pkg::PH_ID; bif_q <= '0; acc_q <= '0; lbl_q <= '0; nce_q <= '0;
			al_q <= '0; ca_q <= '0; rt_q <= '0; rdl_q <= '0;
		end else begin
			if (cfg_we) max_q <= cfg_wdata;
			if (accept) begin
				ph_q <= ph_n; bif_q <= bif_n; acc_q <= acc_n; lbl_q <= lbl_n; nce_q <= nce_n;
				al_q <= al_n; ca_q <= ca_n; rt_q <= rt_n; rdl_q <= rdl_n;
			end
		end
	end

endmodule

### hdl/dmfp_serializer.sv
// result register that hands out one bundled result per request
// depends on dmfp_pkg and dmfp_if
`timescale 1ns / 1ps
module dmfp_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dmfp_pkg::bundle_t bundle,
	output logic              can_load,
	dmfp_out_if.source        out_ch
);

	logic              busy_q;
	logic [2:0]        pos_q;
	dmfp_pkg::bundle_t bundle_q;
	logic              last, take;

	assign last = (pos_q == bundle_q.count - 3'd1);
	assign take = busy_q && out_ch.ready;
	assign can_load = !busy_q || (take && last);

	assign out_ch.valid        = busy_q;
	assign out_ch.field_kind   = bundle_q.kind[pos_q];
	assign out_ch.field_value  = bundle_q.value[pos_q];
	assign out_ch.answer_index = bundle_q.idx[pos_q];
	assign out_ch.last_of_run  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
		end else if (load && bundle.count != 3'd0) begin
			busy_q <= 1'b1;
			pos_q <= '0;
		end else if (take && last) begin
			busy_q <= 1'b0;
		end else if (take) begin
			pos_q <= pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && bundle.count != 3'd0) bundle_q <= bundle;
	end

endmodule

### hdl/dns_message_field_parser_core.sv
// top level of the dns message field parser
// depends on dmfp_pkg, dmfp_if, dmfp_parser, dmfp_serializer
`timescale 1ns / 1ps
// usage
//   in_ch carries one message byte per request plus start_of_message,
//   which restarts the parse with that byte as the first id byte
//   out_ch carries tagged fields: kind, value, answer index, last_of_run
//   cfg_we / cfg_wdata set max_name_length (reset 255); write only when idle
// latency and throughput
//   a byte is decoded in the cycle it is taken; its results appear on
//   out_ch from the next cycle, one per cycle while out_ch is ready
//   a byte with up to one result sustains one byte per cycle while out_ch
//   is ready; a byte with n results holds the result register until all n
//   are taken (flag bytes give five and two), as the single output port
//   drains the bundle; bytes with no result are not loaded, but still wait
//   while an earlier bundle is draining
// reset
//   state returns to the id phase, result register empty, limit 255
// stall
//   while out_ch is held, the result register keeps its bundle and in_ch
//   ready stays low until the last result of it is taken
module dns_message_field_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	dmfp_in_if.sink    in_ch,
	dmfp_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	dmfp_pkg::bundle_t bundle;
	logic              can_load;
	logic              accept;

	// a new byte is taken whenever the result register is free or emptying
	assign in_ch.ready = can_load;
	assign accept = in_ch.valid && can_load;

	dmfp_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.data_byte        (in_ch.data_byte),
		.start_of_message (in_ch.start_of_message),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.bundle           (bundle)
	);

	dmfp_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.bundle   (bundle),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

endmodule

### tb/testbench.sv
// self-checking testbench for dns_message_field_parser_core
// depends on dmfp_pkg, dmfp_if and the core; predicts every field and compares in order
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic [4:0]  kind;
		logic [31:0] value;
		logic [15:0] idx;
		logic        last;
	} field_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_wdata = 0;

	dmfp_in_if  in_ch ();
	dmfp_out_if out_ch ();

	dns_message_field_parser_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [7:0]  lim;
	logic [4:0]  phase;
	logic [1:0]  bif;
	logic [31:0] acc;
	logic [7:0]  lbl_left;
	logic [7:0]  chars;
	logic [15:0] ans_left;
	logic [15:0] cur_ans;
	logic [15:0] rtype;
	logic [15:0] rd_left;

	field_t expected_fields[$];
	field_t step_out[$];
	int n_err = 0, n_seen = 0, n_bytes = 0, n_done = 0, idle_cyc = 0;
	bit timed_out = 0;

	function automatic void put(logic [4:0] k, logic [31:0] v);
		field_t f;
		f.kind = k; f.value = v; f.idx = cur_ans; f.last = 0;
		step_out.push_back(f);
	endfunction

	function automatic bit gather(logic [7:0] b, int len);
		acc = (bif == 2'd0) ? {24'd0, b} : {acc[23:0], b};
		if (int'(bif) + 1 >= len) begin
			bif = 2'd0;
			return 1;
		end
		bif = bif + 2'd1;
		return 0;
	endfunction

	function automatic void name_char(logic [4:0] k, logic [7:0] c);
		if (chars < lim) begin
			put(k, {24'd0, c});
			chars++;
		end
	endfunction

	function automatic void finish_answer();
		cur_ans++;
		ans_left--;
		if (ans_left == 16'd0) begin
			put(dmfp_pkg::K_DONE, 32'd0);
			phase = dmfp_pkg::PH_DONE;
		end else
			phase = dmfp_pkg::PH_ANAME_LEN;
	endfunction

	function automatic bit len_byte(logic [7:0] b, logic [4:0] chr_ph);
		if (b == 8'd0) begin
			chars = 8'd0;
			return 1;
		end
		lbl_left = b;
		phase = chr_ph;
		return 0;
	endfunction

	function automatic void chr_byte(logic [7:0] b, logic [4:0] k, logic [4:0] len_ph);
		name_char(k, b);
		lbl_left--;
		if (lbl_left == 8'd0) begin
			name_char(k, dmfp_pkg::LABEL_MARK);
			phase = len_ph;
		end
	endfunction

	function automatic void clear_parse();
		phase = dmfp_pkg::PH_ID; bif = '0; acc = '0; lbl_left = '0; chars = '0;
		ans_left = '0; cur_ans = '0; rtype = '0; rd_left = '0;
	endfunction

	// work out fields for one accepted byte and queue them
	function automatic void predict_fields(logic [7:0] b, logic som);
		step_out.delete();
		if (som) clear_parse();
		case (phase)
			dmfp_pkg::PH_ID: if (gather(b, 2)) begin
				put(dmfp_pkg::K_ID, acc); phase = dmfp_pkg::PH_FLAGS1;
			end
			dmfp_pkg::PH_FLAGS1: begin
				put(dmfp_pkg::K_QR, {31'd0, b[7]});
				put(dmfp_pkg::K_OPCODE, {28'd0, b[6:3]});
				put(dmfp_pkg::K_AA, {31'd0, b[2]});
				put(dmfp_pkg::K_TC, {31'd0, b[1]});
				put(dmfp_pkg::K_RD, {31'd0, b[0]});
				phase = dmfp_pkg::PH_FLAGS2;
			end
			dmfp_pkg::PH_FLAGS2: begin
				put(dmfp_pkg::K_RA, {31'd0, b[7]});
				put(dmfp_pkg::K_RCODE, {28'd0, b[3:0]});
				phase = dmfp_pkg::PH_QD;
			end
			dmfp_pkg::PH_QD, dmfp_pkg::PH_AN, dmfp_pkg::PH_NS, dmfp_pkg::PH_AR:
				if (gather(b, 2)) begin
					put(dmfp_pkg::K_QDCOUNT + (phase - dmfp_pkg::PH_QD), acc);
					if (phase == dmfp_pkg::PH_AN) ans_left = acc[15:0];
					phase = phase + 5'd1;
				end
			dmfp_pkg::PH_QNAME_LEN:
				if (len_byte(b, dmfp_pkg::PH_QNAME_CHR)) phase = dmfp_pkg::PH_QTYPE;
			dmfp_pkg::PH_QNAME_CHR: chr_byte(b, dmfp_pkg::K_QNAME, dmfp_pkg::PH_QNAME_LEN);
			dmfp_pkg::PH_QTYPE: if (gather(b, 2)) begin
				put(dmfp_pkg::K_QTYPE, acc); phase = dmfp_pkg::PH_QCLASS;
			end
			dmfp_pkg::PH_QCLASS: if (gather(b, 2)) begin
				put(dmfp_pkg::K_QCLASS, acc);
				cur_ans = '0;
				if (ans_left == 16'd0) begin
					put(dmfp_pkg::K_DONE, 32'd0);
					phase = dmfp_pkg::PH_DONE;
				end else
					phase = dmfp_pkg::PH_ANAME_LEN;
			end
			dmfp_pkg::PH_ANAME_LEN:
				if (len_byte(b, dmfp_pkg::PH_ANAME_CHR)) phase = dmfp_pkg::PH_TYPE;
			dmfp_pkg::PH_ANAME_CHR: chr_byte(b, dmfp_pkg::K_ANAME, dmfp_pkg::PH_ANAME_LEN);
			dmfp_pkg::PH_TYPE: if (gather(b, 2)) begin
				put(dmfp_pkg::K_TYPE, acc); rtype = acc[15:0]; phase = dmfp_pkg::PH_CLASS;
			end
			dmfp_pkg::PH_CLASS: if (gather(b, 2)) begin
				put(dmfp_pkg::K_CLASS, acc); phase = dmfp_pkg::PH_TTL;
			end
			dmfp_pkg::PH_TTL: if (gather(b, 4)) begin
				put(dmfp_pkg::K_TTL, acc); phase = dmfp_pkg::PH_RDLEN;
			end
			dmfp_pkg::PH_RDLEN: if (gather(b, 2)) begin
				put(dmfp_pkg::K_RDLEN, acc);
				rd_left = acc[15:0];
				if (rtype == dmfp_pkg::TYPE_A) phase = dmfp_pkg::PH_IP;
				else if (rtype == dmfp_pkg::TYPE_NS || rtype == dmfp_pkg::TYPE_CNAME)
					phase = dmfp_pkg::PH_RNAME_LEN;
				else if (rtype == dmfp_pkg::TYPE_MX) phase = dmfp_pkg::PH_MXPREF;
				else if (rd_left == 16'd0) finish_answer();
				else phase = dmfp_pkg::PH_SKIP;
			end
			dmfp_pkg::PH_IP: if (gather(b, 4)) begin
				put(dmfp_pkg::K_IP, acc); finish_answer();
			end
			dmfp_pkg::PH_MXPREF: if (gather(b, 2)) begin
				put(dmfp_pkg::K_MXPREF, acc); phase = dmfp_pkg::PH_RNAME_LEN;
			end
			dmfp_pkg::PH_RNAME_LEN: if (len_byte(b, dmfp_pkg::PH_RNAME_CHR)) finish_answer();
			dmfp_pkg::PH_RNAME_CHR:
				chr_byte(b, (rtype == dmfp_pkg::TYPE_MX) ? dmfp_pkg::K_MXNAME : dmfp_pkg::K_RNAME,
					dmfp_pkg::PH_RNAME_LEN);
			dmfp_pkg::PH_SKIP: begin
				rd_left--;
				if (rd_left == 16'd0) finish_answer();
			end
			default: phase = dmfp_pkg::PH_DONE;
		endcase
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
		foreach (step_out[i]) begin
			if (step_out[i].kind == dmfp_pkg::K_DONE) n_done++;
			expected_fields.push_back(step_out[i]);
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// sink side: random ready, compare each taken field with the oldest expectation
	int stall_left = 0;
	initial out_ch.ready = 0;
	always @(posedge clk) begin
		field_t e;
		if (out_ch.valid && out_ch.ready) begin
			n_seen++;
			if (expected_fields.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected field kind %0d value %h", out_ch.field_kind,
						out_ch.field_value);
			end else begin
				e = expected_fields.pop_front();
				if (out_ch.field_kind !== e.kind || out_ch.field_value !== e.value ||
						out_ch.answer_index !== e.idx || out_ch.last_of_run !== e.last) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp k=%0d v=%h a=%0d l=%0d got k=%0d v=%h a=%0d l=%0d",
							e.kind, e.value, e.idx, e.last, out_ch.field_kind,
							out_ch.field_value, out_ch.answer_index, out_ch.last_of_run);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = gap_len();
			out_ch.ready <= 0;
		end else
			out_ch.ready <= 1;
	end

	// watchdog on cycles with no request taken on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= 5000 && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired");
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 0;
		in_ch.data_byte = 0;
		in_ch.start_of_message = 0;
	end

	// send one byte request, with a random gap first; predict when taken
	task automatic send_byte(logic [7:0] b, logic som);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data_byte <= b;
		in_ch.start_of_message <= som;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_fields(b, som);
		n_bytes++;
	endtask

	task automatic go_idle();
		in_ch.valid <= 0;
		@(posedge clk);
		while (expected_fields.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_limit(logic [7:0] v);
		go_idle();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		lim = v;
		@(posedge clk);
	endtask

	task automatic send16(logic [15:0] v);
		send_byte(v[15:8], 1'b0);
		send_byte(v[7:0], 1'b0);
	endtask

	task automatic send_name(int nlabels, int maxlen);
		int len;
		for (int i = 0; i < nlabels; i++) begin
			len = $urandom_range(1, maxlen);
			send_byte(len[7:0], 1'b0);
			repeat (len) send_byte(8'($urandom), 1'b0);
		end
		send_byte(8'd0, 1'b0);
	endtask

	// message of valid layout with random content; rdlength matches the rdata only for unknown types
	task automatic send_message(int nans);
		logic [15:0] t;
		int rl;
		send_byte(8'($urandom), 1'b1);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b0);
		send16(16'($urandom));
		send16(nans[15:0]);
		send16(16'($urandom));
		send16(16'($urandom));
		send_name($urandom_range(0, 3), 6);
		send16(16'($urandom));
		send16(16'($urandom));
		for (int a = 0; a < nans; a++) begin
			send_name($urandom_range(0, 2), 5);
			case ($urandom_range(0, 4))
				0: t = dmfp_pkg::TYPE_A;
				1: t = dmfp_pkg::TYPE_NS;
				2: t = dmfp_pkg::TYPE_CNAME;
				3: t = dmfp_pkg::TYPE_MX;
				default: t = 16'($urandom);
			endcase
			send16(t);
			send16(16'($urandom));
			send16(16'($urandom));
			send16(16'($urandom));
			rl = $urandom_range(0, 5);
			send16(rl[15:0]);
			if (t == dmfp_pkg::TYPE_A) repeat (4) send_byte(8'($urandom), 1'b0);
			else if (t == dmfp_pkg::TYPE_NS || t == dmfp_pkg::TYPE_CNAME)
				send_name($urandom_range(0, 2), 5);
			else if (t == dmfp_pkg::TYPE_MX) begin
				send16(16'($urandom));
				send_name($urandom_range(0, 2), 5);
			end else
				repeat (rl) send_byte(8'($urandom), 1'b0);
		end
	endtask

	// header extremes, a restart mid-name, a question with no answers and bytes after done
	task automatic test_directed();
		send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
		send16(16'hFFFF); send16(16'd1); send16(16'h0000); send16(16'hFFFF);
		send_byte(8'd192, 1'b0); repeat (2) send_byte(8'h61, 1'b0);
		// restart mid-name
		send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
		send16(16'd0); send16(16'd0); send16(16'd0); send16(16'd0);
		send_byte(8'd0, 1'b0); send16(dmfp_pkg::TYPE_A); send16(16'd1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
	endtask

	task automatic test_records();
		send_message(2);
	endtask

	task automatic test_name_limit();
		set_limit(8'd1);
		send_message(1);
		set_limit(8'd0);
		send_message(1);
		set_limit(8'd255);
	endtask

	task automatic test_random();
		while (n_bytes < 200) begin
			if ($urandom_range(0, 9) < 8)
				send_message($urandom_range(0, 4));
			else
				repeat ($urandom_range(1, 20))
					send_byte(8'($urandom), $urandom_range(0, 9) == 0);
		end
		set_limit(8'($urandom_range(1, 254)));
		send_message(1);
	endtask

	initial begin
		lim = dmfp_pkg::MaxNameReset;
		clear_parse();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_records();
		test_name_limit();
		test_random();
		go_idle();
		repeat (20) @(posedge clk);
		$display("bytes sent %0d, fields checked %0d, messages completed %0d",
			n_bytes, n_seen, n_done);
		$display("covered header, question, a/ns/cname/mx/unknown rdata, name limits");
		if (n_err == 0 && expected_fields.size() == 0)
			$display("All tests passed");
		else begin
			$display("errors %0d, fields left over %0d", n_err, expected_fields.size());
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
